/* rtl/swish_pkg.sv */
// ----------------------------------------------------------------------------
// swish_pkg: shared types, constants and table builder
// Widths, table geometry and the elaboration-time sigmoid table generator
// used by every stage of the swish pipeline.
// ----------------------------------------------------------------------------
package swish_pkg;

    // Element format
    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 8;

    // Sigmoid table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W     = $clog2(TABLE_DEPTH + 1);

    // Sigmoid values are unsigned Q1.15, 0 .. 1.0 inclusive
    localparam int SIG_FRAC    = 15;
    localparam int SIG_W       = SIG_FRAC + 1;
    localparam int EXP_Q       = 24;

    // Table span is [-8, 8); offset x + 8 fits in FRAC_BITS + 4 bits
    localparam int SPAN        = 8 << FRAC_BITS;
    localparam int OFF_W       = FRAC_BITS + 4;
    // Range-check width: holds the element and +/- SPAN without wrap
    localparam int XW          = ((DATA_WIDTH > FRAC_BITS + 5) ?
                                  DATA_WIDTH : FRAC_BITS + 5) + 1;

    // Product and rounded product widths
    localparam int PW          = DATA_WIDTH + SIG_W + 1;
    localparam int YW          = PW - SIG_FRAC;

    typedef enum logic [1:0] {
        SEL_TABLE,
        SEL_ZERO,
        SEL_ONE
    } t_sig_sel;

    // Control travelling alongside each word in the pipe
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // Shift-subtract division; only ever evaluated at elaboration
    function automatic logic [63:0] sig_udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(num/den) in Q24: 13-term series of e^(x/16), then four squarings
    function automatic logic [63:0] sig_exp_q24(input logic [63:0] num,
                                                input logic [63:0] den);
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] sum;
        u    = sig_udiv(num << EXP_Q, den << 4);
        term = 64'd1 << EXP_Q;
        sum  = term;
        for (int n = 1; n <= 12; n++) begin
            term = sig_udiv((term * u) >> EXP_Q, 64'(n));
            sum  = sum + term;
        end
        for (int i = 0; i < 4; i++) begin
            sum = (sum * sum) >> EXP_Q;
        end
        return sum;
    endfunction

    // Sigmoid at the centre of bin k, Q1.15, rounded to nearest
    function automatic logic [SIG_W-1:0] sig_entry(input int k);
        logic signed [63:0] num;
        logic [63:0]        mag;
        logic [63:0]        e;
        logic [63:0]        den;
        logic [63:0]        lo_val;
        num    = 64'(16 * k + 8) - 64'(8 * TABLE_DEPTH);
        mag    = (num < 0) ? 64'(-num) : 64'(num);
        e      = sig_exp_q24(mag, 64'(TABLE_DEPTH));
        den    = (64'd1 << EXP_Q) + e;
        lo_val = sig_udiv((64'd1 << (EXP_Q + SIG_FRAC)) + (den >> 1), den);
        if (num >= 0)
            return SIG_W'((64'd1 << SIG_FRAC) - lo_val);
        else
            return SIG_W'(lo_val);
    endfunction

endpackage

/* rtl/swish_activation_top.sv */
// ----------------------------------------------------------------------------
// swish_activation_top: element-wise swish (SiLU) activation
// Four-stage pipeline computing y = x * sigmoid(x) on signed Q8.8 words.
// ----------------------------------------------------------------------------
// Takes one word per clock: busy is low whenever reset is released, so a
// word is accepted at every edge where start is high. Each result appears
// on o_sample_out / o_last_out with o_valid high for exactly one cycle,
// in order of arrival, once its word has passed the four register
// stages: range check and table index, sigmoid table read, multiply,
// then round and saturate. The receiver cannot stall the pipe, so
// results must be taken as they come. Sigmoid comes from a 256-entry
// constant table over [-8, 8), 0 below the span and 1.0 at or above it;
// the product is rounded to nearest, ties away from zero, and clamped to
// the signed 16-bit range. o_last_out is a copy of i_last_in.
// ----------------------------------------------------------------------------
module swish_activation_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [swish_pkg::DATA_WIDTH-1:0]  i_sample_in,
    input  logic                                     i_last_in,
    output logic                                     o_valid,
    output logic signed [swish_pkg::DATA_WIDTH-1:0]  o_sample_out,
    output logic                                     o_last_out
);
    import swish_pkg::*;

    t_ctl                          in_ctl;
    t_ctl                          idx_ctl;
    t_ctl                          rom_ctl;
    t_ctl                          out_ctl;
    logic signed [DATA_WIDTH-1:0]  idx_x;
    logic signed [DATA_WIDTH-1:0]  rom_x;
    t_sig_sel                      idx_sel;
    logic [IDX_W-1:0]              idx_idx;
    logic [SIG_W-1:0]              rom_sig;

    // Hold off words only while reset is applied
    assign busy = ~i_rst_n;

    // Tag the incoming word; the valid bit travels with it down the pipe
    assign in_ctl.valid = start & ~busy;
    assign in_ctl.last  = i_last_in;

    // Stage 1: classify against the table span and form the bin index
    swish_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_x     (i_sample_in),
        .o_ctl   (idx_ctl),
        .o_x     (idx_x),
        .o_sel   (idx_sel),
        .o_idx   (idx_idx)
    );

    // Stage 2: read sigmoid, forcing 0 or 1.0 outside the span
    swish_sig_rom u_sig_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (idx_ctl),
        .i_x     (idx_x),
        .i_sel   (idx_sel),
        .i_idx   (idx_idx),
        .o_ctl   (rom_ctl),
        .o_x     (rom_x),
        .o_sig   (rom_sig)
    );

    // Stages 3 and 4: multiply, then round and saturate into the output register
    swish_mul_rnd u_mul_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rom_ctl),
        .i_x     (rom_x),
        .i_sig   (rom_sig),
        .o_ctl   (out_ctl),
        .o_y     (o_sample_out)
    );

    assign o_valid    = out_ctl.valid;
    assign o_last_out = out_ctl.last;

`ifndef ASSERT_OFF
    // Every accepted word yields a result at the end of the pipe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("swish: accepted word produced no result after four cycles");

    // The end-of-blob flag stays with its own word
    a_last_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_out == $past(i_last_in, 4)))
        else $error("swish: last flag out of step with its word");

    // Swish keeps the sign of its input whenever the result is non-zero
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_sample_out != '0)) |->
        (o_sample_out[DATA_WIDTH-1] == $past(i_sample_in[DATA_WIDTH-1], 4)))
        else $error("swish: result sign differs from input sign");
`endif

endmodule

/* rtl/swish_index.sv */
// ----------------------------------------------------------------------------
// swish_index: range check and table index stage
// Classifies the element against [-8, 8) and forms the sigmoid table index.
// ----------------------------------------------------------------------------
module swish_index (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  swish_pkg::t_ctl                          i_ctl,
    input  logic signed [swish_pkg::DATA_WIDTH-1:0]  i_x,
    output swish_pkg::t_ctl                          o_ctl,
    output logic signed [swish_pkg::DATA_WIDTH-1:0]  o_x,
    output swish_pkg::t_sig_sel                      o_sel,
    output logic [swish_pkg::IDX_W-1:0]              o_idx
);
    import swish_pkg::*;

    localparam logic signed [XW-1:0] SPAN_X = XW'(SPAN);
    localparam int MW = OFF_W + DEPTH_W;

    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] off;
    logic [MW-1:0]        prod;
    logic [DEPTH_W-1:0]   idx_full;
    logic [IDX_W-1:0]     n_idx;
    t_sig_sel             n_sel;

    t_ctl                          r_ctl;
    logic signed [DATA_WIDTH-1:0]  r_x;
    t_sig_sel                      r_sel;
    logic [IDX_W-1:0]              r_idx;

    always_comb begin
        x_ext    = {{(XW - DATA_WIDTH){i_x[DATA_WIDTH-1]}}, i_x};
        off      = x_ext + SPAN_X;
        // bin = (x + 8) * depth / 16, the divide being a shift
        prod     = MW'(off[OFF_W-1:0]) * MW'(TABLE_DEPTH);
        idx_full = prod[MW-1:OFF_W];
        if (idx_full >= DEPTH_W'(TABLE_DEPTH))
            n_idx = IDX_W'(TABLE_DEPTH - 1);
        else
            n_idx = idx_full[IDX_W-1:0];
        if (x_ext < -SPAN_X)
            n_sel = SEL_ZERO;
        else if (x_ext >= SPAN_X)
            n_sel = SEL_ONE;
        else
            n_sel = SEL_TABLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_x   <= i_x;
        r_sel <= n_sel;
        r_idx <= n_idx;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_sel = r_sel;
    assign o_idx = r_idx;

endmodule

/* rtl/swish_sig_rom.sv */
// ----------------------------------------------------------------------------
// swish_sig_rom: sigmoid look-up stage
// Constant sigmoid table, built at elaboration, with span clamping.
// ----------------------------------------------------------------------------
module swish_sig_rom (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  swish_pkg::t_ctl                          i_ctl,
    input  logic signed [swish_pkg::DATA_WIDTH-1:0]  i_x,
    input  swish_pkg::t_sig_sel                      i_sel,
    input  logic [swish_pkg::IDX_W-1:0]              i_idx,
    output swish_pkg::t_ctl                          o_ctl,
    output logic signed [swish_pkg::DATA_WIDTH-1:0]  o_x,
    output logic [swish_pkg::SIG_W-1:0]              o_sig
);
    import swish_pkg::*;

    logic [SIG_W-1:0] sig_rom [TABLE_DEPTH];
    logic [SIG_W-1:0] n_sig;

    t_ctl                          r_ctl;
    logic signed [DATA_WIDTH-1:0]  r_x;
    logic [SIG_W-1:0]              r_sig;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
        localparam logic [SIG_W-1:0] ENTRY = sig_entry(k);
        assign sig_rom[k] = ENTRY;
    end

    always_comb begin
        case (i_sel)
            SEL_ZERO: n_sig = '0;
            SEL_ONE:  n_sig = SIG_W'(1) << SIG_FRAC;
            default:  n_sig = sig_rom[i_idx];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_x   <= i_x;
        r_sig <= n_sig;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_sig = r_sig;

endmodule

/* rtl/swish_mul_rnd.sv */
// ----------------------------------------------------------------------------
// swish_mul_rnd: multiply, round and saturate stages
// Registers x * sigmoid, then rounds half away from zero and clamps.
// ----------------------------------------------------------------------------
module swish_mul_rnd (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  swish_pkg::t_ctl                          i_ctl,
    input  logic signed [swish_pkg::DATA_WIDTH-1:0]  i_x,
    input  logic [swish_pkg::SIG_W-1:0]              i_sig,
    output swish_pkg::t_ctl                          o_ctl,
    output logic signed [swish_pkg::DATA_WIDTH-1:0]  o_y
);
    import swish_pkg::*;

    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (SIG_FRAC - 1);
    localparam logic signed [YW-1:0] Y_MAX = YW'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

    logic signed [PW-1:0]         x_ext;
    logic signed [PW-1:0]         s_ext;
    logic signed [PW-1:0]         n_prod;
    logic signed [PW-1:0]         rnd;
    logic signed [YW-1:0]         y_wide;
    logic signed [DATA_WIDTH-1:0] n_y;

    t_ctl                          r_ctl_m;
    logic signed [PW-1:0]          r_prod;
    t_ctl                          r_ctl_o;
    logic signed [DATA_WIDTH-1:0]  r_y;

    always_comb begin
        x_ext  = {{(PW - DATA_WIDTH){i_x[DATA_WIDTH-1]}}, i_x};
        s_ext  = {{(PW - SIG_W){1'b0}}, i_sig};
        n_prod = x_ext * s_ext;
    end

    // Half away from zero: drop one from the bias for negative products
    always_comb begin
        rnd    = r_prod + ROUND_HALF - PW'(r_prod[PW-1]);
        y_wide = rnd[PW-1:SIG_FRAC];
        if (y_wide > Y_MAX)
            n_y = Y_MAX[DATA_WIDTH-1:0];
        else if (y_wide < Y_MIN)
            n_y = Y_MIN[DATA_WIDTH-1:0];
        else
            n_y = y_wide[DATA_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_m <= '0;
            r_ctl_o <= '0;
        end else begin
            r_ctl_m <= i_ctl;
            r_ctl_o <= r_ctl_m;
        end
        r_prod <= n_prod;
        r_y    <= n_y;
    end

    assign o_ctl = r_ctl_o;
    assign o_y   = r_y;

endmodule

/* tb/swish_checker.sv */
// ----------------------------------------------------------------------------
// swish_checker: scoreboard for the swish activation pipeline
// Watches the command and result channels, predicts the swish of every
// accepted word and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module swish_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic                                    i_busy,
    input  logic signed [swish_pkg::DATA_WIDTH-1:0] i_sample_in,
    input  logic                                    i_last_in,
    input  logic                                    i_valid,
    input  logic signed [swish_pkg::DATA_WIDTH-1:0] i_sample_out,
    input  logic                                    i_last_out,
    output int                                      o_mismatches,
    output int                                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW    = swish_pkg::DATA_WIDTH;
    localparam int FB    = swish_pkg::FRAC_BITS;
    localparam int DEPTH = swish_pkg::TABLE_DEPTH;
    localparam int SF    = swish_pkg::SIG_FRAC;
    localparam int EQ    = swish_pkg::EXP_Q;
    localparam int HALF_SPAN = 8 << FB;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [DW-1:0] sample;
        logic                 last;
    } word_t;

    int unsigned sig_lut [DEPTH];
    word_t       swish_queue [$];
    int          n_bad = 0;

    // Sigmoid at each bin centre, Q1.15, via a Q24 series for e^|c|
    initial begin : build_lut
        longint          num;
        longint unsigned mag, u, term, acc, den, lo_v;
        for (int k = 0; k < DEPTH; k++) begin
            num  = longint'(16 * k + 8) - longint'(8 * DEPTH);
            mag  = (num < 0) ? longint'(-num) : longint'(num);
            u    = (mag << EQ) / (64'd16 * DEPTH);
            term = 64'd1 << EQ;
            acc  = term;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * u) >> EQ) / longint'(n);
                acc  = acc + term;
            end
            for (int s = 0; s < 4; s++)
                acc = (acc * acc) >> EQ;
            den  = (64'd1 << EQ) + acc;
            lo_v = ((64'd1 << (EQ + SF)) + den / 2) / den;
            sig_lut[k] = (num >= 0) ? int'((64'd1 << SF) - lo_v) : int'(lo_v);
        end
    end

    function automatic logic signed [DW-1:0] swish_of(input logic signed [DW-1:0] x);
        longint xi, sg, p, mag, y, hi;
        longint idx;
        xi = x;
        if (xi < -HALF_SPAN) begin
            sg = 0;
        end else if (xi >= HALF_SPAN) begin
            sg = longint'(1) << SF;
        end else begin
            idx = ((xi + HALF_SPAN) * DEPTH) / (longint'(16) << FB);
            if (idx > DEPTH - 1)
                idx = DEPTH - 1;
            sg = sig_lut[idx];
        end
        p   = xi * sg;
        // round half away from zero
        mag = (p < 0) ? -p : p;
        mag = (mag + (longint'(1) << (SF - 1))) >> SF;
        y   = (p < 0) ? -mag : mag;
        hi  = (longint'(1) << (DW - 1)) - 1;
        if (y > hi)
            y = hi;
        if (y < -hi - 1)
            y = -hi - 1;
        return y[DW-1:0];
    endfunction

    always @(posedge i_clk) begin
        word_t want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (swish_queue.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("%0t: unexpected result sample=%0d last=%0b",
                                 $time, i_sample_out, i_last_out);
                end else begin
                    want = swish_queue.pop_front();
                    if (i_sample_out !== want.sample || i_last_out !== want.last) begin
                        n_bad++;
                        if (n_bad <= MAX_REPORTS)
                            $display("%0t: mismatch sample exp=%0d got=%0d, last exp=%0b got=%0b",
                                     $time, want.sample, i_sample_out, want.last, i_last_out);
                    end
                end
            end
            if (i_start && !i_busy)
                swish_queue.push_back('{sample: swish_of(i_sample_in), last: i_last_in});
        end
        o_mismatches <= n_bad;
        o_pending    <= swish_queue.size();
    end

endmodule

/* tb/swish_activation_top_tb.sv */
// ----------------------------------------------------------------------------
// swish_activation_top_tb: stimulus and verdict for the swish pipeline
// Drives directed edge cases then random words with idle bursts into the
// block; a side checker predicts each swish result and counts mismatches.
// ----------------------------------------------------------------------------
module swish_activation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW         = swish_pkg::DATA_WIDTH;
    localparam int HALF_SPAN  = 8 << swish_pkg::FRAC_BITS;
    localparam int BIN_W      = (16 << swish_pkg::FRAC_BITS) / swish_pkg::TABLE_DEPTH;
    localparam int N_RANDOM   = 1430;
    // final stretch of the run is sent back to back, no idling
    localparam int QUIET_TAIL = 200;
    // pipe is four stages deep; allow slack before the verdict
    localparam int DRAIN_WAIT = 12;
    localparam int WATCHDOG   = 2000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [DW-1:0] i_sample_in;
    logic                 i_last_in;
    logic                 o_valid;
    logic signed [DW-1:0] o_sample_out;
    logic                 o_last_out;

    int mismatches;
    int pending;
    int quiet_cycles = 0;

    swish_activation_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample_in  (i_sample_in),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

    swish_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_sample_in  (i_sample_in),
        .i_last_in    (i_last_in),
        .i_valid      (o_valid),
        .i_sample_out (o_sample_out),
        .i_last_out   (o_last_out),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: count cycles in which no word moves on either channel
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one word and hold it until the block takes it. Start is left
    // high so that a following word goes out back to back; the caller drops
    // it when it wants a gap.
    task automatic send_word(input logic signed [DW-1:0] x, input logic last);
        start       <= 1'b1;
        i_sample_in <= x;
        i_last_in   <= last;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop start and hold until the checker has seen every result. The first
    // edge lets the checker account for the word taken at the current edge.
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Pick a random element, weighted towards the table span and its edges
    function automatic logic signed [DW-1:0] pick_sample();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3, 4: begin
                v = $urandom_range(0, 2 * HALF_SPAN + 200) - HALF_SPAN - 100;
            end
            5, 6: begin
                v = $urandom;
            end
            7: begin
                // straddle either end of the span
                v = ($urandom_range(0, 1) ? HALF_SPAN : -HALF_SPAN)
                    + $urandom_range(0, 8) - 4;
            end
            8: begin
                // land on or beside a bin boundary
                v = ($urandom_range(0, 255) - 128) * BIN_W + $urandom_range(0, 2) - 1;
            end
            default: begin
                v = $urandom_range(0, 64) - 32;
            end
        endcase
        return v[DW-1:0];
    endfunction

    initial begin
        int directed [$];
        int i;

        start       <= 1'b0;
        i_sample_in <= '0;
        i_last_in   <= 1'b0;
        i_rst_n     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n     <= 1'b1;

        // Directed part: full-scale extremes, zero and unit steps, both ends
        // of the table span (below it, its first bin, its last bin, at and
        // above plus one), bin boundaries, half and whole values.
        directed = '{-32768, 32767, 0, -1, 1,
                     -HALF_SPAN - 1, -HALF_SPAN, -HALF_SPAN + 1,
                     HALF_SPAN - 1, HALF_SPAN, HALF_SPAN + 1,
                     -BIN_W, -BIN_W - 1, BIN_W - 1, BIN_W,
                     128, -128, 256, -256, 4096, -4096};
        i = 0;
        foreach (directed[k]) begin
            send_word(DW'(directed[k]), i[0]);
            i++;
        end

        // Random part
        for (int n = 0; n < N_RANDOM; n++) begin
            send_word(pick_sample(), ($urandom_range(0, 15) == 0));
            if (n == N_RANDOM / 2)
                drain_pipe();
            else if (n < N_RANDOM - QUIET_TAIL && $urandom_range(0, 5) == 0)
                idle_for($urandom_range(1, 12));
        end

        // Wait for the pipe to empty, then let any stray result surface
        drain_pipe();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
